// ----- hdl/cartesian_to_spherical_unit_defines.svh -----
// Assertion macros for the Cartesian to spherical unit.
// Expects signals named clk and rst in the including scope.
`ifndef CARTESIAN_TO_SPHERICAL_UNIT_DEFINES_SVH
`define CARTESIAN_TO_SPHERICAL_UNIT_DEFINES_SVH

// implication in the same cycle
`define C2S_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication in the next cycle
`define C2S_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/c2s_pkg.sv -----
// Shared types, constants and elaboration-time functions for the
// Cartesian to spherical unit. No dependencies.
`timescale 1ns / 1ps
package c2s_pkg;

  localparam int CW = 32;         // coordinate width, Q16.16
  localparam int RW = 32;         // radius width
  localparam int PW = 30;         // polar angle width, Q2.28
  localparam int AW = 31;         // azimuth width, Q3.28
  localparam int ROOT_BITS = 32;  // root bits of a 64-bit square root

  localparam logic signed [63:0] Q60_PI       = 64'sh3243F6A8885A308D;
  localparam logic signed [63:0] Q60_HALF_PI  = 64'sh1921FB54442D1846;
  localparam logic signed [63:0] Q60_3HALF_PI = 64'sh4B65F1FCCC8748D3;
  localparam logic signed [63:0] Q60_TWO_PI   = 64'sh6487ED5110B4611A;
  localparam logic signed [63:0] Q60_QUART_PI = 64'sh0C90FDAA22168C23;

  localparam logic [PW-1:0] PI_Q28     = 30'd843314857;
  localparam logic [AW-1:0] TWO_PI_Q28 = 31'd1686629713;

  typedef struct packed {
    logic origin;
    logic z_zero;
    logic x_zero;
    logic y_zero;
    logic xn;
    logic yn;
    logic zn;
  } flags_t;

  // square root stage: radius path (r) and xy-projection path (p)
  typedef struct packed {
    logic [63:0] rem_r;
    logic [31:0] root_r;
    logic [63:0] rem_p;
    logic [31:0] root_p;
    logic [59:0] zs;
    logic [31:0] xm;
    logic [31:0] ym;
    flags_t      fl;
  } sq_t;

  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] ang;
  } rot_t;

  // rotation stage: polar path (p) and azimuth path (a)
  typedef struct packed {
    rot_t        p;
    rot_t        a;
    logic [RW-1:0] radius;
    flags_t      fl;
  } it_t;

  typedef struct packed {
    logic [RW-1:0] radius;
    logic [PW-1:0] polar_angle;
    logic [AW-1:0] azimuth;
  } res_t;

  // floor(2^n / d) by restoring long division, elaboration only
  function automatic logic [63:0] pow2_div(input int n, input int d);
    logic [63:0] q;
    int r;
    q = '0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      if (b <= n) begin
        r = 2 * r + ((b == n) ? 1 : 0);
        if (r >= d) begin
          r = r - d;
          q[b] = 1'b1;
        end
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q4.60 from the truncated arctangent series
  function automatic logic [63:0] atan_q60(input int i);
    logic [63:0] sum;
    logic [63:0] term;
    int e;
    sum = '0;
    if (i == 0) begin
      sum = Q60_QUART_PI;
    end else begin
      for (int k = 0; k < 31; k++) begin
        e = i * (2 * k + 1);
        if (e <= 60) begin
          term = pow2_div(60 - e, 2 * k + 1);
          if (k % 2 == 1) sum = sum - term;
          else sum = sum + term;
        end
      end
    end
    return sum;
  endfunction

endpackage

// ----- hdl/c2s_if.sv -----
// Valid/ready channel interfaces of the Cartesian to spherical unit.
// Depends on c2s_pkg for the payload widths.
`timescale 1ns / 1ps
interface c2s_pt_if import c2s_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] x_in;
  logic signed [CW-1:0] y_in;
  logic signed [CW-1:0] z_in;
  modport source (output valid, output x_in, output y_in, output z_in, input ready);
  modport sink   (input valid, input x_in, input y_in, input z_in, output ready);
endinterface

interface c2s_sph_if import c2s_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [RW-1:0] radius;
  logic [PW-1:0] polar_angle;
  logic [AW-1:0] azimuth;
  modport source (output valid, output radius, output polar_angle, output azimuth,
                  input ready);
  modport sink   (input valid, input radius, input polar_angle, input azimuth,
                  output ready);
endinterface

// ----- hdl/cartesian_to_spherical_unit.sv -----
// Cartesian to spherical unit: fully pipelined, one point per cycle while the output buffer has room.
// Depends on c2s_pkg, c2s_if and cartesian_to_spherical_unit_defines.svh.
`timescale 1ns / 1ps
`include "cartesian_to_spherical_unit_defines.svh"

// Converts a Q16.16 point (x, y, z) to radius (Q16.16), polar angle (Q2.28)
// and azimuth (Q3.28), both in radians. Throughput is one item per clock
// while the output buffer is not full. The pipe has five front stages
// (magnitudes, squares, sums, normalize search, shift), 32 square root
// stages (one root bit each, radius and xy projection side by side), one
// rounding stage, three CORDIC operand normalize stages, one vectoring
// CORDIC stage per iteration for each angle, three angle fix-up stages and
// a two-entry output buffer. The whole pipe holds only when that buffer
// is full, so input ready never depends combinationally on output ready.
module cartesian_to_spherical_unit import c2s_pkg::*; #(
  parameter int ANGLE_ITERATIONS = 28
) (
  input  logic            clk,
  input  logic            rst,
  c2s_pt_if.sink          pt,
  c2s_sph_if.source       sph
);

  logic       adv;
  logic [1:0] cnt;

  assign adv      = (cnt != 2'd2);
  assign pt.ready = adv;

  // ---------------- S1: magnitudes and flags
  logic        s1_v;
  logic [31:0] s1_xm, s1_ym, s1_zm;
  flags_t      s1_fl;

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (adv) s1_v <= pt.valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_xm <= pt.x_in[CW-1] ? 32'(-pt.x_in) : 32'(pt.x_in);
      s1_ym <= pt.y_in[CW-1] ? 32'(-pt.y_in) : 32'(pt.y_in);
      s1_zm <= pt.z_in[CW-1] ? 32'(-pt.z_in) : 32'(pt.z_in);
      s1_fl.x_zero <= (pt.x_in == '0);
      s1_fl.y_zero <= (pt.y_in == '0);
      s1_fl.z_zero <= (pt.z_in == '0);
      s1_fl.origin <= (pt.x_in == '0) && (pt.y_in == '0) && (pt.z_in == '0);
      s1_fl.xn <= pt.x_in[CW-1];
      s1_fl.yn <= pt.y_in[CW-1];
      s1_fl.zn <= pt.z_in[CW-1];
    end
  end

  // ---------------- S2: squares
  logic        s2_v;
  logic [63:0] s2_xx, s2_yy, s2_zz;
  logic [31:0] s2_xm, s2_ym, s2_zm;
  flags_t      s2_fl;

  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (adv) s2_v <= s1_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_xx <= 64'(s1_xm) * 64'(s1_xm);
      s2_yy <= 64'(s1_ym) * 64'(s1_ym);
      s2_zz <= 64'(s1_zm) * 64'(s1_zm);
      s2_xm <= s1_xm;
      s2_ym <= s1_ym;
      s2_zm <= s1_zm;
      s2_fl <= s1_fl;
    end
  end

  // ---------------- S3: sums
  logic        s3_v;
  logic [63:0] s3_sxy, s3_s3;
  logic [31:0] s3_xm, s3_ym, s3_zm;
  flags_t      s3_fl;

  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (adv) s3_v <= s2_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_sxy <= s2_xx + s2_yy;
      s3_s3  <= s2_xx + s2_yy + s2_zz;
      s3_xm  <= s2_xm;
      s3_ym  <= s2_ym;
      s3_zm  <= s2_zm;
      s3_fl  <= s2_fl;
    end
  end

  // ---------------- S4: common scale for x^2+y^2 and |z|
  logic [30:0] hit;
  logic [4:0]  t_sel;

  always_comb begin
    for (int t = 0; t < 31; t++) begin
      hit[t] = ((s3_sxy >> (60 - 2 * t)) != 64'd0) ||
               ((64'(s3_zm) >> (59 - t)) != 64'd0);
    end
    t_sel = 5'd30;
    for (int t = 30; t >= 0; t--) begin
      if (hit[t]) t_sel = 5'(t);
    end
  end

  logic        s4_v;
  logic [4:0]  s4_t;
  logic [63:0] s4_sxy, s4_s3;
  logic [31:0] s4_xm, s4_ym, s4_zm;
  flags_t      s4_fl;

  always_ff @(posedge clk) begin
    if (rst) s4_v <= 1'b0;
    else if (adv) s4_v <= s3_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_t   <= t_sel;
      s4_sxy <= s3_sxy;
      s4_s3  <= s3_s3;
      s4_xm  <= s3_xm;
      s4_ym  <= s3_ym;
      s4_zm  <= s3_zm;
      s4_fl  <= s3_fl;
    end
  end

  // ---------------- S5 and square root stages
  sq_t  sq_q [0:ROOT_BITS];
  logic sq_v [0:ROOT_BITS];

  always_ff @(posedge clk) begin
    if (rst) sq_v[0] <= 1'b0;
    else if (adv) sq_v[0] <= s4_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_q[0].rem_r  <= s4_s3;
      sq_q[0].root_r <= '0;
      sq_q[0].rem_p  <= s4_sxy << {s4_t, 1'b0};
      sq_q[0].root_p <= '0;
      sq_q[0].zs     <= 60'(64'(s4_zm) << s4_t);
      sq_q[0].xm     <= s4_xm;
      sq_q[0].ym     <= s4_ym;
      sq_q[0].fl     <= s4_fl;
    end
  end

  for (genvar j = 0; j < ROOT_BITS; j++) begin : g_sqrt
    localparam int K = ROOT_BITS - 1 - j;
    logic [65:0] trial_r, trial_p;
    sq_t         nxt;

    always_comb begin
      trial_r = (66'(sq_q[j].root_r) << (K + 1)) + (66'd1 << (2 * K));
      trial_p = (66'(sq_q[j].root_p) << (K + 1)) + (66'd1 << (2 * K));
      nxt = sq_q[j];
      if (66'(sq_q[j].rem_r) >= trial_r) begin
        nxt.rem_r  = 64'(66'(sq_q[j].rem_r) - trial_r);
        nxt.root_r = sq_q[j].root_r | (32'd1 << K);
      end
      if (66'(sq_q[j].rem_p) >= trial_p) begin
        nxt.rem_p  = 64'(66'(sq_q[j].rem_p) - trial_p);
        nxt.root_p = sq_q[j].root_p | (32'd1 << K);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) sq_v[j+1] <= 1'b0;
      else if (adv) sq_v[j+1] <= sq_v[j];
    end

    always_ff @(posedge clk) begin
      if (adv) sq_q[j+1] <= nxt;
    end
  end

  // ---------------- radius rounding and CORDIC operands
  localparam sq_t SQ_LAST_DUMMY = '0;  // width reference only
  logic          po_v;
  logic [RW-1:0] po_radius;
  flags_t        po_fl;
  logic [59:0]   po_ap;
  logic [31:0]   po_bp, po_aa, po_ba;
  logic          po_np, po_na;

  always_ff @(posedge clk) begin
    if (rst) po_v <= 1'b0;
    else if (adv) po_v <= sq_v[ROOT_BITS];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      po_radius <= sq_q[ROOT_BITS].root_r +
                   32'(sq_q[ROOT_BITS].rem_r > 64'(sq_q[ROOT_BITS].root_r));
      po_fl <= sq_q[ROOT_BITS].fl | SQ_LAST_DUMMY.fl;
      po_ap <= sq_q[ROOT_BITS].zs;
      po_bp <= sq_q[ROOT_BITS].root_p;
      po_np <= sq_q[ROOT_BITS].fl.zn;
      po_aa <= sq_q[ROOT_BITS].xm;
      po_ba <= sq_q[ROOT_BITS].ym;
      po_na <= sq_q[ROOT_BITS].fl.xn ^ sq_q[ROOT_BITS].fl.yn;
    end
  end

  // ---------------- N1: larger operand
  logic          n1_v;
  logic [59:0]   n1_mp, n1_ap;
  logic [31:0]   n1_ma, n1_bp, n1_aa, n1_ba;
  logic          n1_np, n1_na;
  logic [RW-1:0] n1_radius;
  flags_t        n1_fl;

  always_ff @(posedge clk) begin
    if (rst) n1_v <= 1'b0;
    else if (adv) n1_v <= po_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n1_mp <= (po_ap > 60'(po_bp)) ? po_ap : 60'(po_bp);
      n1_ma <= (po_aa > po_ba) ? po_aa : po_ba;
      n1_ap <= po_ap;
      n1_bp <= po_bp;
      n1_aa <= po_aa;
      n1_ba <= po_ba;
      n1_np <= po_np;
      n1_na <= po_na;
      n1_radius <= po_radius;
      n1_fl <= po_fl;
    end
  end

  // ---------------- N2: shift that puts the larger operand in [2^59, 2^60)
  logic [5:0] shp_c, sha_c;

  always_comb begin
    shp_c = '0;
    sha_c = '0;
    for (int b = 0; b < 60; b++) begin
      if (n1_mp[b]) shp_c = 6'(59 - b);
    end
    for (int b = 0; b < 32; b++) begin
      if (n1_ma[b]) sha_c = 6'(59 - b);
    end
  end

  logic          n2_v;
  logic [5:0]    n2_shp, n2_sha;
  logic [59:0]   n2_ap;
  logic [31:0]   n2_bp, n2_aa, n2_ba;
  logic          n2_np, n2_na;
  logic [RW-1:0] n2_radius;
  flags_t        n2_fl;

  always_ff @(posedge clk) begin
    if (rst) n2_v <= 1'b0;
    else if (adv) n2_v <= n1_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n2_shp <= shp_c;
      n2_sha <= sha_c;
      n2_ap <= n1_ap;
      n2_bp <= n1_bp;
      n2_aa <= n1_aa;
      n2_ba <= n1_ba;
      n2_np <= n1_np;
      n2_na <= n1_na;
      n2_radius <= n1_radius;
      n2_fl <= n1_fl;
    end
  end

  // ---------------- N3: shift, start vectors
  it_t  it_q [0:ANGLE_ITERATIONS];
  logic it_v [0:ANGLE_ITERATIONS];
  logic [63:0] bp_sh, ba_sh;

  assign bp_sh = 64'(n2_bp) << n2_shp;
  assign ba_sh = 64'(n2_ba) << n2_sha;

  always_ff @(posedge clk) begin
    if (rst) it_v[0] <= 1'b0;
    else if (adv) it_v[0] <= n2_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it_q[0].p.x   <= $signed(64'(n2_ap) << n2_shp);
      it_q[0].p.y   <= n2_np ? -$signed(bp_sh) : $signed(bp_sh);
      it_q[0].p.ang <= '0;
      it_q[0].a.x   <= $signed(64'(n2_aa) << n2_sha);
      it_q[0].a.y   <= n2_na ? -$signed(ba_sh) : $signed(ba_sh);
      it_q[0].a.ang <= '0;
      it_q[0].radius <= n2_radius;
      it_q[0].fl <= n2_fl;
    end
  end

  // ---------------- vectoring CORDIC, one micro rotation per stage
  for (genvar i = 0; i < ANGLE_ITERATIONS; i++) begin : g_rot
    localparam logic signed [63:0] ATAN_I = $signed(atan_q60(i));
    it_t nxt;

    always_comb begin
      nxt = it_q[i];
      // a zero second operand ends the rotation: later stages pass through
      if (it_q[i].p.y != 64'sd0) begin
        if (!it_q[i].p.y[63]) begin
          nxt.p.x   = it_q[i].p.x + (it_q[i].p.y >>> i);
          nxt.p.y   = it_q[i].p.y - (it_q[i].p.x >>> i);
          nxt.p.ang = it_q[i].p.ang + ATAN_I;
        end else begin
          nxt.p.x   = it_q[i].p.x - (it_q[i].p.y >>> i);
          nxt.p.y   = it_q[i].p.y + (it_q[i].p.x >>> i);
          nxt.p.ang = it_q[i].p.ang - ATAN_I;
        end
      end
      if (it_q[i].a.y != 64'sd0) begin
        if (!it_q[i].a.y[63]) begin
          nxt.a.x   = it_q[i].a.x + (it_q[i].a.y >>> i);
          nxt.a.y   = it_q[i].a.y - (it_q[i].a.x >>> i);
          nxt.a.ang = it_q[i].a.ang + ATAN_I;
        end else begin
          nxt.a.x   = it_q[i].a.x - (it_q[i].a.y >>> i);
          nxt.a.y   = it_q[i].a.y + (it_q[i].a.x >>> i);
          nxt.a.ang = it_q[i].a.ang - ATAN_I;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) it_v[i+1] <= 1'b0;
      else if (adv) it_v[i+1] <= it_v[i];
    end

    always_ff @(posedge clk) begin
      if (adv) it_q[i+1] <= nxt;
    end
  end

  // ---------------- F1: quadrant offsets and axis cases
  logic               f1_v;
  logic signed [63:0] f1_pol, f1_azi;
  logic [RW-1:0]      f1_radius;
  flags_t             fl_last;

  assign fl_last = it_q[ANGLE_ITERATIONS].fl;

  always_ff @(posedge clk) begin
    if (rst) f1_v <= 1'b0;
    else if (adv) f1_v <= it_v[ANGLE_ITERATIONS];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      priority if (fl_last.origin) f1_pol <= '0;
      else if (fl_last.z_zero)     f1_pol <= Q60_HALF_PI;
      else f1_pol <= (fl_last.zn ? Q60_PI : 64'sd0) + it_q[ANGLE_ITERATIONS].p.ang;

      priority if (fl_last.x_zero && fl_last.y_zero) f1_azi <= '0;
      else if (fl_last.x_zero) f1_azi <= fl_last.yn ? Q60_3HALF_PI : Q60_HALF_PI;
      else f1_azi <= (fl_last.xn ? Q60_PI : 64'sd0) + it_q[ANGLE_ITERATIONS].a.ang;

      f1_radius <= it_q[ANGLE_ITERATIONS].radius;
    end
  end

  // ---------------- F2: polar saturation, azimuth wrap
  logic               f2_v;
  logic signed [63:0] f2_pol, f2_azi;
  logic [RW-1:0]      f2_radius;

  always_ff @(posedge clk) begin
    if (rst) f2_v <= 1'b0;
    else if (adv) f2_v <= f1_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      priority if (f1_pol < 64'sd0) f2_pol <= '0;
      else if (f1_pol > Q60_PI)     f2_pol <= Q60_PI;
      else                          f2_pol <= f1_pol;
      f2_azi    <= (f1_azi < 64'sd0) ? f1_azi + Q60_TWO_PI : f1_azi;
      f2_radius <= f1_radius;
    end
  end

  // ---------------- F3: azimuth saturation, rounding to Q2.28 and Q3.28
  logic               f3_v;
  res_t               f3_res;
  logic signed [63:0] azi_sat;
  logic [63:0]        pol_rnd, azi_rnd;

  always_comb begin
    priority if (f2_azi < 64'sd0) azi_sat = '0;
    else if (f2_azi > Q60_TWO_PI) azi_sat = Q60_TWO_PI;
    else                          azi_sat = f2_azi;
    pol_rnd = $unsigned(f2_pol) + 64'h0000_0000_8000_0000;
    azi_rnd = $unsigned(azi_sat) + 64'h0000_0000_8000_0000;
  end

  always_ff @(posedge clk) begin
    if (rst) f3_v <= 1'b0;
    else if (adv) f3_v <= f2_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f3_res.radius      <= f2_radius;
      f3_res.polar_angle <= pol_rnd[61:32];
      f3_res.azimuth     <= azi_rnd[62:32];
    end
  end

  // ---------------- two-entry output buffer
  res_t ob [0:1];
  logic wr_ptr, rd_ptr;
  logic push, pop;

  assign push = adv && f3_v;
  assign pop  = sph.valid && sph.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) ob[wr_ptr] <= f3_res;
  end

  assign sph.valid       = (cnt != 2'd0);
  assign sph.radius      = ob[rd_ptr].radius;
  assign sph.polar_angle = ob[rd_ptr].polar_angle;
  assign sph.azimuth     = ob[rd_ptr].azimuth;

  // ---------------- checks
  `C2S_ASSERT_NOW(a_pol_range, sph.valid, sph.polar_angle <= PI_Q28, "polar angle above pi")
  `C2S_ASSERT_NOW(a_azi_range, sph.valid, sph.azimuth <= TWO_PI_Q28, "azimuth above 2pi")
  `C2S_ASSERT_NEXT(a_cnt_up, push && !pop, cnt == $past(cnt) + 2'd1, "buffer count slip")
  `C2S_ASSERT_NEXT(a_hold_last, f3_v && !adv, f3_v && $stable(f3_res), "held item lost")

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for cartesian_to_spherical_unit: directed and random points,
// checked against an in-bench fixed-point predictor under random handshake gaps.
// Depends on c2s_pkg, c2s_if and the unit's RTL.
`timescale 1ns / 1ps

class sph_scoreboard;
  localparam int ITERS = 28;
  c2s_pkg::res_t expected_q[$];
  int            mismatches;

  function new();
    mismatches = 0;
  endfunction

  // atan(2^-i) in Q4.60 from the truncated arctangent series
  static function logic signed [63:0] atan_step(int i);
    logic signed [63:0] sum;
    logic [63:0]        term;
    int                 k;
    int                 e;
    if (i == 0) return c2s_pkg::Q60_QUART_PI;
    sum = 0;
    k = 0;
    e = i;
    while (e <= 60) begin
      term = (64'd1 << (60 - e)) / (2 * k + 1);
      if (k % 2 == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
      k++;
      e += 2 * i;
    end
    return sum;
  endfunction

  static function logic [63:0] root64(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // vectoring rotation: angle of (xm, +-ym) in Q4.60
  static function logic signed [63:0] vec_angle(logic [63:0] xm, logic [63:0] ym, bit yneg);
    logic [63:0]        m;
    logic signed [63:0] vx;
    logic signed [63:0] vy;
    logic signed [63:0] nx;
    logic signed [63:0] ang;
    m = (xm > ym) ? xm : ym;
    ang = 0;
    if (m == 0) return 0;
    while (m < (64'd1 << 59)) begin
      m = m << 1;
      xm = xm << 1;
      ym = ym << 1;
    end
    vx = xm;
    vy = yneg ? -$signed(ym) : $signed(ym);
    for (int i = 0; i < ITERS; i++) begin
      if (vy == 0) break;
      if (vy > 0) begin
        nx = vx + (vy >>> i);
        vy = vy - (vx >>> i);
        ang = ang + atan_step(i);
      end else begin
        nx = vx - (vy >>> i);
        vy = vy + (vx >>> i);
        ang = ang - atan_step(i);
      end
      vx = nx;
    end
    return ang;
  endfunction

  static function c2s_pkg::res_t convert(logic signed [31:0] x, logic signed [31:0] y,
                                         logic signed [31:0] z);
    c2s_pkg::res_t      r;
    logic [63:0]        xm, ym, zm, sxy, s3, q, rho, zs;
    logic signed [63:0] pol, azi;
    int                 t;
    xm = (x < 0) ? -64'(x) : 64'(x);
    ym = (y < 0) ? -64'(y) : 64'(y);
    zm = (z < 0) ? -64'(z) : 64'(z);
    r = '0;
    if (xm == 0 && ym == 0 && zm == 0) return r;
    sxy = xm * xm + ym * ym;
    s3 = sxy + zm * zm;
    q = root64(s3);
    if (s3 - q * q > q) q++;
    if (zm == 0) begin
      pol = c2s_pkg::Q60_HALF_PI;
    end else begin
      t = 0;
      while (t < 30 && (sxy >> (60 - 2 * t)) == 0 && (zm >> (59 - t)) == 0) t++;
      rho = root64(sxy << (2 * t));
      zs = zm << t;
      if (z >= 0) pol = vec_angle(zs, rho, 0);
      else pol = c2s_pkg::Q60_PI + vec_angle(zs, rho, 1);
      if (pol < 0) pol = 0;
      if (pol > c2s_pkg::Q60_PI) pol = c2s_pkg::Q60_PI;
    end
    if (xm == 0) begin
      azi = (ym == 0) ? 64'sd0 : ((y < 0) ? c2s_pkg::Q60_3HALF_PI : c2s_pkg::Q60_HALF_PI);
    end else begin
      if (x < 0) azi = c2s_pkg::Q60_PI + vec_angle(xm, ym, y > 0);
      else azi = vec_angle(xm, ym, y < 0);
      if (azi < 0) azi = azi + c2s_pkg::Q60_TWO_PI;
      if (azi < 0) azi = 0;
      if (azi > c2s_pkg::Q60_TWO_PI) azi = c2s_pkg::Q60_TWO_PI;
    end
    r.radius = q[31:0];
    r.polar_angle = 30'((64'(pol) + (64'd1 << 31)) >> 32);
    r.azimuth = 31'((64'(azi) + (64'd1 << 31)) >> 32);
    return r;
  endfunction

  function void note_point(logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [31:0] z);
    expected_q.insert(expected_q.size(), convert(x, y, z));
  endfunction

  function void check_result(c2s_pkg::res_t got);
    c2s_pkg::res_t exp_r;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    exp_r = expected_q.pop_front();
    if (got.radius !== exp_r.radius || got.polar_angle !== exp_r.polar_angle ||
        got.azimuth !== exp_r.azimuth) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: radius %h/%h polar %h/%h azimuth %h/%h (exp/got)",
                 exp_r.radius, got.radius, exp_r.polar_angle, got.polar_angle,
                 exp_r.azimuth, got.azimuth);
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module testbench;
  import c2s_pkg::*;

  localparam int LATENCY     = 73;
  localparam int STALL_LIMIT = 5000;
  localparam int N_RANDOM    = 1600;

  logic clk;
  logic rst;
  bit   quiet;       // no idling on either side
  int   hold_cnt;    // receiver hold-off, in cycles
  int   stall_cnt;

  c2s_pt_if  pt();
  c2s_sph_if sph();

  sph_scoreboard sb = new();

  cartesian_to_spherical_unit dut (.clk(clk), .rst(rst), .pt(pt.sink), .sph(sph.source));

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // receiver
  initial begin
    sph.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cnt > 0) begin
        hold_cnt--;
        sph.ready <= 1'b0;
      end else begin
        sph.ready <= quiet || ($urandom_range(99) >= 12);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pt.valid && pt.ready) sb.note_point(pt.x_in, pt.y_in, pt.z_in);
    if (!rst && sph.valid && sph.ready)
      sb.check_result('{sph.radius, sph.polar_angle, sph.azimuth});
  end

  always @(posedge clk) begin
    if (rst || (pt.valid && pt.ready) || (sph.valid && sph.ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z);
    while (!quiet && $urandom_range(99) < 12) begin
      @(negedge clk);
      pt.valid <= 1'b0;
    end
    @(negedge clk);
    pt.valid <= 1'b1;
    pt.x_in <= x;
    pt.y_in <= y;
    pt.z_in <= z;
    do @(posedge clk); while (!pt.ready);
  endtask

  function automatic logic signed [31:0] pick_coord(int mode);
    logic signed [31:0] v;
    case (mode)
      0: v = $urandom;
      1: v = $signed($urandom_range(8191)) - 4096;
      2: v = $signed($urandom) >>> $urandom_range(31);
      3: v = 0;
      default: begin
        case ($urandom_range(4))
          0: v = 32'sh80000000;
          1: v = 32'sh7FFFFFFF;
          2: v = 1;
          3: v = -1;
          default: v = 0;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic send_random();
    int m;
    m = $urandom_range(9);
    if (m < 4)
      send_point(pick_coord(0), pick_coord(0), pick_coord(0));
    else if (m < 6)
      send_point(pick_coord(2), pick_coord(2), pick_coord(2));
    else if (m == 6)
      send_point(pick_coord(1), pick_coord(1), pick_coord(1));
    else
      send_point(pick_coord($urandom_range(4)), pick_coord($urandom_range(4)),
                 pick_coord($urandom_range(4)));
  endtask

  initial begin
    logic signed [31:0] dir_pts [][3];
    hold_cnt = 0;
    quiet = 0;
    rst = 1'b1;
    pt.valid <= 1'b0;
    pt.x_in <= '0;
    pt.y_in <= '0;
    pt.z_in <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    dir_pts = '{
      '{0, 0, 0},                          // origin
      '{32'sh10000, 0, 0}, '{-32'sh10000, 0, 0},
      '{0, 32'sh10000, 0}, '{0, -32'sh10000, 0},
      '{0, 0, 32'sh10000}, '{0, 0, -32'sh10000},
      '{32'sh80000000, 32'sh80000000, 32'sh80000000},
      '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF},
      '{32'sh80000000, 32'sh7FFFFFFF, 0},
      '{1, 1, 1}, '{-1, -1, -1}, '{1, 0, 0}, '{0, 0, 1},
      '{0, 0, 32'sh80000000}, '{0, 32'sh80000000, 5},
      '{-32'sh12345, 0, 32'sh777}, '{32'sh10000, -32'sh10000, 0},
      '{-32'sh10000, 32'sh10000, -32'sh10000}, '{-1, 1, 0},
      '{32'sh7FFFFFFF, -1, 32'sh80000000}
    };
    foreach (dir_pts[i]) send_point(dir_pts[i][0], dir_pts[i][1], dir_pts[i][2]);

    for (int n = 0; n < N_RANDOM; n++) begin
      quiet = (n >= 600 && n < 900);
      if (n == 300) hold_cnt = 400;  // output backs up, input must stall
      if (n == 1000) begin
        // drain completely before continuing
        @(negedge clk);
        pt.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
      send_random();
    end
    @(negedge clk);
    pt.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
